>>> rtl/core/tsob_pkg.sv
// ----------------------------------------------------------------------------
// tsob_pkg
// Types and constants shared by the TCP SYN option builder.
// ----------------------------------------------------------------------------
package tsob_pkg;

	localparam logic [31:0] CAPACITY_LIMIT = 32'h4000_0000;
	localparam logic [31:0] MSS_CAP        = 32'd65535;
	localparam int          SHIFT_MAX      = 14;

	// option kinds and lengths
	localparam logic [7:0] OPT_KIND_MSS  = 8'd2;
	localparam logic [7:0] OPT_LEN_MSS   = 8'd4;
	localparam logic [7:0] OPT_KIND_SACK = 8'd4;
	localparam logic [7:0] OPT_LEN_SACK  = 8'd2;
	localparam logic [7:0] OPT_KIND_TS   = 8'd8;
	localparam logic [7:0] OPT_LEN_TS    = 8'd10;
	localparam logic [7:0] OPT_KIND_WS   = 8'd3;
	localparam logic [7:0] OPT_LEN_WS    = 8'd3;

	// positions in the full option layout
	localparam logic [4:0] POS_MSS_LO  = 5'd3;
	localparam logic [4:0] POS_SACK    = 5'd4;
	localparam logic [4:0] POS_SACK_LO = 5'd5;
	localparam logic [4:0] POS_TS      = 5'd6;
	localparam logic [4:0] POS_TS_END  = 5'd15;
	localparam logic [4:0] POS_WS      = 5'd16;
	localparam logic [4:0] POS_WS_END  = 5'd18;

	// configuration register indexes
	localparam logic [1:0] REG_RCV_BUF = 2'd0;
	localparam logic [1:0] REG_WS_EN   = 2'd1;
	localparam logic [1:0] REG_TS_EN   = 2'd2;
	localparam logic [1:0] REG_SACK_EN = 2'd3;

	typedef struct packed {
		logic        rejected;
		logic [15:0] mss;
		logic [3:0]  shift;
		logic        ws_en;
		logic        ts_en;
		logic        sack_en;
		logic [31:0] ts;
	} syn_desc_t;

endpackage

>>> rtl/core/tcp_syn_option_builder.sv
// ----------------------------------------------------------------------------
// tcp_syn_option_builder
// Encodes the option block of a TCP SYN: MSS, SACK-permitted, timestamp and
// window scale, or a single rejection item.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  request   | start, busy               | transport_message_bytes, ts_value
//  result    | result_strobe             | option_byte, byte_index, last_byte,
//            |                           | offer_rejected
//  config    | cfg_wr_en                 | cfg_addr, cfg_wdata
//
// A request of n octets (1 when rejected, else 4 to 19) holds the emitter until
// its last octet; the emitter's one-octet-per-cycle walk sets the rate.
// The first octet passes queue, current-request and output registers.
// Requests queue up to QUEUE_DEPTH deep; busy is high while the queue is full.
// Reset restores the register defaults and empties queue and emitter.
// Results cannot be stalled: each octet is shown for one cycle only.
// ----------------------------------------------------------------------------
module tcp_syn_option_builder import tsob_pkg::*; #(
	parameter int MIN_HEADER_BYTES = 20,
	parameter int QUEUE_DEPTH      = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] transport_message_bytes,
	input  logic [31:0] ts_value,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	output logic        result_strobe,
	output logic [7:0]  option_byte,
	output logic [4:0]  byte_index,
	output logic        last_byte,
	output logic        offer_rejected
);

	logic [31:0] rcv_buf_q;
	logic        ws_en_q;
	logic        ts_en_q;
	logic        sack_en_q;

	syn_desc_t   front_desc;
	syn_desc_t   head_desc;
	logic        q_not_empty;
	logic        q_full;
	logic        q_pop;
	logic        push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_buf_q <= 32'd65535;
			ws_en_q   <= 1'b1;
			ts_en_q   <= 1'b1;
			sack_en_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_RCV_BUF: rcv_buf_q <= cfg_wdata;
				REG_WS_EN:   ws_en_q   <= cfg_wdata[0];
				REG_TS_EN:   ts_en_q   <= cfg_wdata[0];
				REG_SACK_EN: sack_en_q <= cfg_wdata[0];
				default:     ;
			endcase
		end
	end

	assign busy = q_full;
	assign push = start && !q_full;

	tsob_front #(
		.MIN_HEADER_BYTES(MIN_HEADER_BYTES)
	) u_front (
		.transport_message_bytes(transport_message_bytes),
		.ts_value               (ts_value),
		.rcv_buf                (rcv_buf_q),
		.ws_en                  (ws_en_q),
		.ts_en                  (ts_en_q),
		.sack_en                (sack_en_q),
		.desc                   (front_desc)
	);

	tsob_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_desc(front_desc),
		.pop      (q_pop),
		.head_desc(head_desc),
		.not_empty(q_not_empty),
		.full     (q_full)
	);

	tsob_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_desc     (head_desc),
		.head_valid    (q_not_empty),
		.pop           (q_pop),
		.result_strobe (result_strobe),
		.option_byte   (option_byte),
		.byte_index    (byte_index),
		.last_byte     (last_byte),
		.offer_rejected(offer_rejected)
	);

	// octets of one item leave on consecutive cycles
	a_item_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_byte |=> result_strobe)
		else $error("gap inside an option block");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_byte |=> byte_index == 5'($past(byte_index) + 5'd1))
		else $error("byte index did not advance by one");

	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && offer_rejected |-> last_byte && byte_index == 5'd0
			&& option_byte == 8'd0)
		else $error("malformed rejection item");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> byte_index <= 5'd18)
		else $error("byte index beyond option block");

endmodule

>>> rtl/core/tsob_front.sv
// ----------------------------------------------------------------------------
// tsob_front
// Classifies a SYN request: rejection check, MSS clamp and window shift.
// ----------------------------------------------------------------------------
module tsob_front import tsob_pkg::*; #(
	parameter int MIN_HEADER_BYTES = 20
) (
	input  logic [31:0] transport_message_bytes,
	input  logic [31:0] ts_value,
	input  logic [31:0] rcv_buf,
	input  logic        ws_en,
	input  logic        ts_en,
	input  logic        sack_en,
	output syn_desc_t   desc
);

	logic [31:0] raw_mss;
	logic [3:0]  shift;

	assign raw_mss = transport_message_bytes - 32'(MIN_HEADER_BYTES);

	// smallest shift with cap < 2^(16+shift), else the maximum; 0 if ws_en is off
	always_comb begin
		shift = 4'(SHIFT_MAX);
		for (int s = SHIFT_MAX; s >= 0; s--) begin
			if ((rcv_buf >> (16 + s)) == 32'd0)
				shift = 4'(s);
		end
		if (!ws_en)
			shift = 4'd0;
	end

	always_comb begin
		desc.rejected = (transport_message_bytes <= 32'(MIN_HEADER_BYTES))
			|| (rcv_buf == 32'd0) || (rcv_buf > CAPACITY_LIMIT);
		desc.mss      = (raw_mss > MSS_CAP) ? MSS_CAP[15:0] : raw_mss[15:0];
		desc.shift    = shift;
		desc.ws_en    = ws_en;
		desc.ts_en    = ts_en;
		desc.sack_en  = sack_en;
		desc.ts       = ts_value;
	end

endmodule

>>> rtl/core/tsob_queue.sv
// ----------------------------------------------------------------------------
// tsob_queue
// Small FIFO of classified requests between front and emitter.
// ----------------------------------------------------------------------------
module tsob_queue import tsob_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  syn_desc_t push_desc,
	input  logic      pop,
	output syn_desc_t head_desc,
	output logic      not_empty,
	output logic      full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	syn_desc_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign head_desc = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

>>> rtl/core/tsob_emit.sv
// ----------------------------------------------------------------------------
// tsob_emit
// Walks the option layout of one request, one octet per cycle.
// ----------------------------------------------------------------------------
module tsob_emit import tsob_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  syn_desc_t head_desc,
	input  logic      head_valid,
	output logic      pop,
	output logic      result_strobe,
	output logic [7:0] option_byte,
	output logic [4:0] byte_index,
	output logic      last_byte,
	output logic      offer_rejected
);

	syn_desc_t  cur_q;
	logic       active_q;
	logic [4:0] pos_q;
	logic [4:0] idx_q;
	logic       strobe_q;
	logic [7:0] byte_q;
	logic [4:0] out_idx_q;
	logic       last_q;
	logic       rej_q;

	logic [7:0] byte_c;
	logic [4:0] next_pos;
	logic       done_c;

	always_comb begin
		case (pos_q)
			5'd0:    byte_c = OPT_KIND_MSS;
			5'd1:    byte_c = OPT_LEN_MSS;
			5'd2:    byte_c = cur_q.mss[15:8];
			5'd3:    byte_c = cur_q.mss[7:0];
			5'd4:    byte_c = OPT_KIND_SACK;
			5'd5:    byte_c = OPT_LEN_SACK;
			5'd6:    byte_c = OPT_KIND_TS;
			5'd7:    byte_c = OPT_LEN_TS;
			5'd8:    byte_c = cur_q.ts[31:24];
			5'd9:    byte_c = cur_q.ts[23:16];
			5'd10:   byte_c = cur_q.ts[15:8];
			5'd11:   byte_c = cur_q.ts[7:0];
			5'd16:   byte_c = OPT_KIND_WS;
			5'd17:   byte_c = OPT_LEN_WS;
			5'd18:   byte_c = {4'd0, cur_q.shift};
			default: byte_c = 8'd0;   // echo reply field
		endcase
		if (cur_q.rejected)
			byte_c = 8'd0;
	end

	// skip disabled options at their boundaries
	always_comb begin
		next_pos = pos_q + 5'd1;
		done_c   = 1'b0;
		case (pos_q)
			POS_MSS_LO: begin
				if (cur_q.sack_en)    next_pos = POS_SACK;
				else if (cur_q.ts_en) next_pos = POS_TS;
				else if (cur_q.ws_en) next_pos = POS_WS;
				else                  done_c   = 1'b1;
			end
			POS_SACK_LO: begin
				if (cur_q.ts_en)      next_pos = POS_TS;
				else if (cur_q.ws_en) next_pos = POS_WS;
				else                  done_c   = 1'b1;
			end
			POS_TS_END: begin
				if (cur_q.ws_en)      next_pos = POS_WS;
				else                  done_c   = 1'b1;
			end
			POS_WS_END: done_c = 1'b1;
			default:    ;
		endcase
		if (cur_q.rejected)
			done_c = 1'b1;
	end

	assign pop = head_valid && (!active_q || done_c);

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head_desc;
		if (active_q) begin
			byte_q    <= byte_c;
			out_idx_q <= idx_q;
			last_q    <= done_c;
			rej_q     <= cur_q.rejected;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				pos_q    <= '0;
				idx_q    <= '0;
			end else if (active_q && done_c) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				pos_q <= next_pos;
				idx_q <= idx_q + 5'd1;
			end
		end
	end

	assign result_strobe  = strobe_q;
	assign option_byte    = byte_q;
	assign byte_index     = out_idx_q;
	assign last_byte      = last_q;
	assign offer_rejected = rej_q;

endmodule

>>> sim/syn_option_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// syn_option_checker
// Watches the request, result and register channels of the SYN option
// builder, predicts the octet stream of every accepted request from its own
// copy of the registers and compares each result octet field by field.
// ----------------------------------------------------------------------------
module syn_option_checker import tsob_pkg::*; #(
	parameter int MIN_HEADER_BYTES = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] transport_message_bytes,
	input  logic [31:0] ts_value,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        result_strobe,
	input  logic [7:0]  option_byte,
	input  logic [4:0]  byte_index,
	input  logic        last_byte,
	input  logic        offer_rejected,
	output int          mismatch_count,
	output int          outstanding
);

	typedef struct packed {
		logic [7:0] octet;
		logic [4:0] pos;
		logic       last;
		logic       rejected;
	} octet_t;

	octet_t      pending_octets[$];
	logic [31:0] rcv_buf;
	logic        ws_en;
	logic        ts_en;
	logic        sack_en;

	function automatic logic [3:0] window_shift(input logic [31:0] cap);
		logic [3:0] sh;
		sh = 4'd0;
		while (sh < SHIFT_MAX && (cap >> sh) > 32'd65535)
			sh++;
		return sh;
	endfunction

	// expected octets of one SYN request under the current registers
	function automatic void predict_option_block(input logic [31:0] size,
			input logic [31:0] tsval);
		logic [7:0]  block[19];
		logic [31:0] raw_mss;
		logic [15:0] mss;
		int          n;
		octet_t      o;
		n = 0;
		if (size <= MIN_HEADER_BYTES || rcv_buf == 32'd0 || rcv_buf > CAPACITY_LIMIT) begin
			o = '{octet: 8'd0, pos: 5'd0, last: 1'b1, rejected: 1'b1};
			pending_octets.push_back(o);
			return;
		end
		raw_mss = size - MIN_HEADER_BYTES;
		mss = (raw_mss > MSS_CAP) ? 16'hFFFF : raw_mss[15:0];
		block[n] = OPT_KIND_MSS; n = n + 1;
		block[n] = OPT_LEN_MSS;  n = n + 1;
		block[n] = mss[15:8];    n = n + 1;
		block[n] = mss[7:0];     n = n + 1;
		if (sack_en) begin
			block[n] = OPT_KIND_SACK; n = n + 1;
			block[n] = OPT_LEN_SACK;  n = n + 1;
		end
		if (ts_en) begin
			block[n] = OPT_KIND_TS; n = n + 1;
			block[n] = OPT_LEN_TS;  n = n + 1;
			for (int i = 3; i >= 0; i--) begin
				block[n] = tsval[8*i +: 8];
				n = n + 1;
			end
			for (int i = 0; i < 4; i++) begin
				block[n] = 8'd0;	// echo reply is always zero on a SYN
				n = n + 1;
			end
		end
		if (ws_en) begin
			block[n] = OPT_KIND_WS;                 n = n + 1;
			block[n] = OPT_LEN_WS;                  n = n + 1;
			block[n] = {4'd0, window_shift(rcv_buf)}; n = n + 1;
		end
		for (int i = 0; i < n; i++) begin
			o = '{octet: block[i], pos: 5'(i), last: (i == n - 1), rejected: 1'b0};
			pending_octets.push_back(o);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		octet_t got;
		octet_t want;
		if (!arst_n) begin
			rcv_buf        <= 32'd65535;
			ws_en          <= 1'b1;
			ts_en          <= 1'b1;
			sack_en        <= 1'b1;
			mismatch_count <= 0;
			outstanding    <= 0;
			pending_octets.delete();
		end else begin
			// results first: an item accepted at this edge cannot have one yet
			if (result_strobe) begin
				got = '{octet: option_byte, pos: byte_index, last: last_byte,
					rejected: offer_rejected};
				if (pending_octets.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: unexpected octet byte=%02h idx=%0d last=%b rej=%b",
							$realtime, got.octet, got.pos, got.last, got.rejected);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = pending_octets.pop_front();
					if (got !== want) begin
						if (mismatch_count < 10)
							$display("%0t: mismatch exp %02h/%0d/%b/%b got %02h/%0d/%b/%b",
								$realtime,
								want.octet, want.pos, want.last, want.rejected,
								got.octet, got.pos, got.last, got.rejected);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (start && !busy)
				predict_option_block(transport_message_bytes, ts_value);
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_RCV_BUF: rcv_buf <= cfg_wdata;
					REG_WS_EN:   ws_en   <= cfg_wdata[0];
					REG_TS_EN:   ts_en   <= cfg_wdata[0];
					REG_SACK_EN: sack_en <= cfg_wdata[0];
					default: ;
				endcase
			end
			outstanding <= pending_octets.size();
		end
	end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// SYN option builder test: directed requests over the size, capacity and
// enable extremes, then random requests over several register settings with
// varying request gaps; octets are checked by syn_option_checker.
// ----------------------------------------------------------------------------
module tb_top import tsob_pkg::*; ();

	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] transport_message_bytes = 32'd0;
	logic [31:0] ts_value = 32'd0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_addr = REG_RCV_BUF;
	logic [31:0] cfg_wdata = 32'd0;
	logic        result_strobe;
	logic [7:0]  option_byte;
	logic [4:0]  byte_index;
	logic        last_byte;
	logic        offer_rejected;
	int          mismatch_count;
	int          outstanding;
	int          gap_pct = 0;
	int          stall_cycles = 0;

	always #5 clk = ~clk;

	tcp_syn_option_builder uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.transport_message_bytes(transport_message_bytes), .ts_value(ts_value),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.result_strobe(result_strobe), .option_byte(option_byte), .byte_index(byte_index),
		.last_byte(last_byte), .offer_rejected(offer_rejected)
	);

	syn_option_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.transport_message_bytes(transport_message_bytes), .ts_value(ts_value),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.result_strobe(result_strobe), .option_byte(option_byte), .byte_index(byte_index),
		.last_byte(last_byte), .offer_rejected(offer_rejected),
		.mismatch_count(mismatch_count), .outstanding(outstanding)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[tcp_syn_option_builder] ERROR");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [31:0] size, input logic [31:0] tsval);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start                   <= 1'b1;
		transport_message_bytes <= size;
		ts_value                <= tsval;
		do @(posedge clk); while (busy);
	endtask

	// stop requesting and let every predicted octet come out
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		wait (outstanding == 0);
		repeat (4) @(negedge clk);
	endtask

	// 1-bit registers get junk in the upper bits: only bit 0 must count
	task automatic set_registers(input logic [31:0] cap, input logic ws, input logic ts,
			input logic sack);
		logic [1:0]  idx[4];
		logic [31:0] val[4];
		idx = '{REG_RCV_BUF, REG_WS_EN, REG_TS_EN, REG_SACK_EN};
		val = '{cap, ($urandom() & ~32'd1) | ws, ($urandom() & ~32'd1) | ts,
			($urandom() & ~32'd1) | sack};
		drain_results();
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_addr  <= idx[i];
			cfg_wdata <= val[i];
			@(negedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [31:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 8)  return $urandom_range(20);
		if (r < 40) return $urandom_range(2000, 21);
		if (r < 70) return $urandom_range(70000, 60000);
		return $urandom();
	endfunction

	function automatic logic [31:0] pick_capacity();
		int r;
		r = $urandom_range(99);
		if (r < 4)  return 32'd0;
		if (r < 8)  return $urandom_range(32'hFFFF_FFFF, 32'h4000_0001);
		if (r < 12) return 32'h4000_0000;
		if (r < 16) return 32'd65536;
		if (r < 20) return $urandom_range(65535, 1);
		return ($urandom_range(32'h4000_0000, 1) >> $urandom_range(16)) | 32'd1;
	endfunction

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset register values: 65535, all options on
		send_request(32'd0, 32'd0);
		send_request(32'd20, 32'hFFFF_FFFF);
		send_request(32'd21, 32'h1234_5678);
		send_request(32'd84, 32'hA5A5_A5A5);
		send_request(32'd65555, 32'h5A5A_5A5A);
		send_request(32'd65556, 32'hFFFF_FFFF);
		send_request(32'hFFFF_FFFF, 32'd0);
		// capacity out of range
		set_registers(32'd0, 1'b1, 1'b1, 1'b1);
		send_request(32'd100, 32'h0BAD_F00D);
		set_registers(32'h4000_0001, 1'b1, 1'b1, 1'b1);
		send_request(32'd1500, 32'h0000_0001);
		set_registers(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
		send_request(32'd1500, 32'h8000_0000);
		// capacity limit: shift saturates at its maximum
		set_registers(32'h4000_0000, 1'b1, 1'b0, 1'b0);
		send_request(32'd1480, 32'hDEAD_BEEF);
		send_request(32'd9000, 32'h0000_FFFF);
		set_registers(32'd65536, 1'b1, 1'b1, 1'b0);
		send_request(32'd576, 32'hFFFF_0000);
		// window scale off
		set_registers(32'd1, 1'b0, 1'b0, 1'b1);
		send_request(32'd40, 32'h7FFF_FFFF);
		set_registers(32'h4000_0000, 1'b0, 1'b0, 1'b0);
		send_request(32'd1000, 32'd0);
		set_registers(32'd200000, 1'b0, 1'b1, 1'b1);
		send_request(32'd65000, 32'hC3C3_C3C3);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				2:       set_registers(32'h4000_0000, 1'b1, 1'b1, 1'b1);
				5:       set_registers(32'd1, 1'b0, 1'b0, 1'b0);
				default: set_registers(pick_capacity(), $urandom_range(1), $urandom_range(1),
						$urandom_range(1));
			endcase
			gap_pct = (ph < 3) ? 11 : (ph < 6) ? 68 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 4 && i == PHASE_ITEMS / 2)
					drain_results();
				send_request(pick_size(), $urandom());
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("[tcp_syn_option_builder] OK");
		else
			$display("[tcp_syn_option_builder] ERROR");
		$finish;
	end

endmodule
